FILE: src/pcbp_pkg.sv
`default_nettype none

package pcbp_pkg;

  localparam int BYTE_W = 8;
  localparam int CODE_FIELD_W = 32;
  localparam int LEN_FIELD_W = 6;
  localparam int SYM_W = 8;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

endpackage

`default_nettype wire

FILE: src/pcbp_ram.sv
`default_nettype none

module pcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/prefix_code_bit_packer.sv
`default_nettype none

// channel  handshake           payload
// in       in_valid, in_stall  kind, symbol, code_bits, code_len
// out      out_valid, out_stall out_byte, error, last
//
// A transfer on in is registered into a merge stage; an encode also reads the
// code table on the way (table RAM port), and a load writes it. Each item leaves
// the merge stage once no full byte is pending, and the encoded bytes follow.
// Reset clears the entry valid marks, the bit count and both stage valids at once.
// An out stall holds the output register and the byte emitter; in stalls once the
// merge stage is occupied and cannot retire.

module prefix_code_bit_packer #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          kind,
  input  wire logic [pcbp_pkg::SYM_W-1:0]          symbol,
  input  wire logic [pcbp_pkg::CODE_FIELD_W-1:0]   code_bits,
  input  wire logic [pcbp_pkg::LEN_FIELD_W-1:0]    code_len,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [pcbp_pkg::BYTE_W-1:0]         out_byte,
  output logic                                     error,
  output logic                                     last
);

  localparam int LEN_LIMIT = (MAX_CODE_LEN > pcbp_pkg::CODE_FIELD_W) ?
                             pcbp_pkg::CODE_FIELD_W : MAX_CODE_LEN;
  localparam int LEN_W = $clog2(LEN_LIMIT + 1);
  localparam int ENTRY_W = LEN_LIMIT + LEN_W;
  localparam int ADDR_W = $clog2(SYMBOL_COUNT);
  localparam int ACC_W = LEN_LIMIT + pcbp_pkg::BYTE_W - 1;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic                    in_take;
  logic                    sym_ok;
  logic [ADDR_W-1:0]       addr;
  logic [LEN_W-1:0]        load_len;
  logic [LEN_LIMIT-1:0]    ones;
  logic [LEN_LIMIT-1:0]    load_bits;
  logic                    ram_we;
  logic                    ram_re;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [SYMBOL_COUNT-1:0] entry_valid;

  logic                    s1_valid;
  pcbp_pkg::kind_t         s1_kind;
  logic                    s1_hit;
  logic [LEN_W-1:0]        s1_len;
  logic [LEN_LIMIT-1:0]    s1_bits;

  logic [ACC_W-1:0]        acc;
  logic [CNT_W-1:0]        cnt;
  logic [ACC_W-1:0]        acc_next;
  logic [CNT_W-1:0]        cnt_next;
  logic [ACC_W-1:0]        w_acc;
  logic [CNT_W-1:0]        w_cnt;
  logic [CNT_W-1:0]        sh;
  logic [ACC_W-1:0]        flush_word;

  logic                    pend;
  logic                    out_free;
  logic                    need_out;
  logic                    take_s1;
  logic                    merge;
  logic                    emit;
  logic                    s1_out;
  logic [pcbp_pkg::BYTE_W-1:0] s1_byte;
  logic                    s1_err;

  assign sym_ok = {1'b0, symbol} < (pcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
  assign addr = symbol[ADDR_W-1:0];
  assign ones = '1;
  assign load_len = (code_len > pcbp_pkg::LEN_FIELD_W'(LEN_LIMIT)) ?
                    LEN_W'(LEN_LIMIT) : code_len[LEN_W-1:0];
  assign load_bits = code_bits[LEN_LIMIT-1:0] & ~(ones << load_len);

  assign in_stall = s1_valid && !take_s1;
  assign in_take = in_valid && !in_stall;
  assign ram_we = in_take && (kind == pcbp_pkg::KIND_LOAD) && sym_ok;
  assign ram_re = in_take && (kind == pcbp_pkg::KIND_ENCODE);

  pcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata({load_len, load_bits}),
    .re   (ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  assign s1_len = ram_rdata[ENTRY_W-1 -: LEN_W];
  assign s1_bits = ram_rdata[LEN_LIMIT-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
      s1_kind  <= pcbp_pkg::kind_t'(kind);
      s1_hit   <= sym_ok && entry_valid[addr];
    end else if (take_s1) begin
      s1_valid <= 1'b0;
    end
  end

  assign pend = cnt >= CNT_W'(pcbp_pkg::BYTE_W);
  assign out_free = !out_valid || !out_stall;
  assign flush_word = acc << (CNT_W'(pcbp_pkg::BYTE_W) - cnt);

  always_comb begin
    need_out = 1'b0;
    merge = 1'b0;
    s1_byte = '0;
    s1_err = 1'b0;
    case (s1_kind)
      pcbp_pkg::KIND_ENCODE: begin
        need_out = !s1_hit;
        merge = s1_hit;
        s1_err = 1'b1;
      end
      pcbp_pkg::KIND_FLUSH: begin
        need_out = cnt != '0;
        s1_byte = flush_word[pcbp_pkg::BYTE_W-1:0];
      end
      default: begin
        need_out = 1'b0;
      end
    endcase
  end

  assign take_s1 = s1_valid && !pend && (!need_out || out_free);
  assign s1_out = take_s1 && need_out;

  always_comb begin
    if (take_s1 && merge) begin
      w_acc = (acc << s1_len) | ACC_W'(s1_bits);
      w_cnt = cnt + CNT_W'(s1_len);
    end else begin
      w_acc = acc;
      w_cnt = cnt;
    end
  end

  assign emit = out_free && (w_cnt >= CNT_W'(pcbp_pkg::BYTE_W)) && !s1_out;
  assign sh = w_cnt - CNT_W'(pcbp_pkg::BYTE_W);

  always_comb begin
    acc_next = w_acc;
    cnt_next = w_cnt;
    if (take_s1 && (s1_kind == pcbp_pkg::KIND_FLUSH)) begin
      acc_next = '0;
      cnt_next = '0;
    end else if (emit) begin
      cnt_next = sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_out) begin
      out_valid <= 1'b1;
      out_byte  <= s1_byte;
      error     <= s1_err;
      last      <= 1'b1;
    end else if (emit) begin
      out_valid <= 1'b1;
      out_byte  <= pcbp_pkg::BYTE_W'(w_acc >> sh);
      error     <= 1'b0;
      last      <= sh < CNT_W'(pcbp_pkg::BYTE_W);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && (out_byte == '0))
    else $error("error result without last or with nonzero byte");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    take_s1 && (s1_kind == pcbp_pkg::KIND_FLUSH) |=> (cnt == '0))
    else $error("flush left pending bits");

  a_more_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error && !last |-> cnt >= CNT_W'(pcbp_pkg::BYTE_W))
    else $error("non-last byte without a following full byte");

  a_no_merge_pending: assert property (@(posedge clk) disable iff (rst)
    pend |-> !take_s1)
    else $error("merge stage retired while bytes were pending");

endmodule

`default_nettype wire

FILE: test/pcbp_checker.sv
`timescale 1ns / 100ps

module pcbp_checker
  import pcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic [1:0]              kind,
  input  wire logic [SYM_W-1:0]        symbol,
  input  wire logic [CODE_FIELD_W-1:0] code_bits,
  input  wire logic [LEN_FIELD_W-1:0]  code_len,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic [BYTE_W-1:0]       out_byte,
  input  wire logic                    error,
  input  wire logic                    last,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              err;
    logic              lst;
  } packed_byte_t;

  logic [CODE_FIELD_W-1:0] code_word [SYMBOL_COUNT];
  int                      code_size [SYMBOL_COUNT];
  logic                    code_known [SYMBOL_COUNT];
  logic [63:0]             pending_bits = '0;
  int                      pending_cnt = 0;
  packed_byte_t            expected_bytes [$];
  packed_byte_t            got;
  int                      mismatches = 0;

  task automatic pack_transfer(input logic [1:0] k, input logic [SYM_W-1:0] s,
                               input logic [CODE_FIELD_W-1:0] b,
                               input logic [LEN_FIELD_W-1:0] l);
    int           size;
    int           lim;
    packed_byte_t e;
    lim = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
    case (k)
      KIND_LOAD: begin
        if (int'(s) < SYMBOL_COUNT) begin
          size = (int'(l) > lim) ? lim : int'(l);
          code_word[s] = b & CODE_FIELD_W'((64'd1 << size) - 64'd1);
          code_size[s] = size;
          code_known[s] = 1'b1;
        end
      end
      KIND_ENCODE: begin
        if (int'(s) >= SYMBOL_COUNT || !code_known[s]) begin
          e.data = '0;
          e.err = 1'b1;
          e.lst = 1'b1;
          expected_bytes.push_back(e);
        end else begin
          pending_bits = (pending_bits << code_size[s]) | 64'(code_word[s]);
          pending_cnt += code_size[s];
          while (pending_cnt >= BYTE_W) begin
            pending_cnt -= BYTE_W;
            e.data = BYTE_W'(pending_bits >> pending_cnt);
            e.err = 1'b0;
            e.lst = (pending_cnt < BYTE_W);
            pending_bits &= (64'd1 << pending_cnt) - 64'd1;
            expected_bytes.push_back(e);
          end
        end
      end
      KIND_FLUSH: begin
        if (pending_cnt > 0) begin
          e.data = BYTE_W'(pending_bits << (BYTE_W - pending_cnt));
          e.err = 1'b0;
          e.lst = 1'b1;
          expected_bytes.push_back(e);
        end
        pending_bits = '0;
        pending_cnt = 0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_bytes.delete();
      for (int i = 0; i < SYMBOL_COUNT; i++) code_known[i] = 1'b0;
      pending_bits = '0;
      pending_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual byte %02h error %0b last %0b",
                   $time, out_byte, error, last);
          mismatches++;
        end else begin
          got = expected_bytes.pop_front();
          if (out_byte !== got.data) begin
            $display("%0t: out_byte: expected %02h, actual %02h", $time, got.data, out_byte);
            mismatches++;
          end
          if (error !== got.err) begin
            $display("%0t: error: expected %0b, actual %0b", $time, got.err, error);
            mismatches++;
          end
          if (last !== got.lst) begin
            $display("%0t: last: expected %0b, actual %0b", $time, got.lst, last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) pack_transfer(kind, symbol, code_bits, code_len);
    end
    fail_count <= mismatches;
    pending <= expected_bytes.size();
  end

endmodule

FILE: test/tb_prefix_code_bit_packer.sv
`timescale 1ns / 100ps

module tb_prefix_code_bit_packer;
  import pcbp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 388;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              kind = KIND_LOAD;
  logic [SYM_W-1:0]        symbol = '0;
  logic [CODE_FIELD_W-1:0] code_bits = '0;
  logic [LEN_FIELD_W-1:0]  code_len = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [BYTE_W-1:0]       out_byte;
  logic                    error;
  logic                    last;
  int                      fail_count;
  int                      pending;
  int                      idle_cycles = 0;
  bit                      no_gaps = 1'b0;

  always #10 clk = ~clk;

  prefix_code_bit_packer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .symbol    (symbol),
    .code_bits (code_bits),
    .code_len  (code_len),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .error     (error),
    .last      (last)
  );

  pcbp_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .symbol     (symbol),
    .code_bits  (code_bits),
    .code_len   (code_len),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .error      (error),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 4);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        n = $urandom_range(5, 30);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(20, 60);
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send(input logic [1:0] k, input logic [SYM_W-1:0] s,
                      input logic [CODE_FIELD_W-1:0] b, input logic [LEN_FIELD_W-1:0] l);
    int g;
    in_valid <= 1'b1;
    kind <= k;
    symbol <= s;
    code_bits <= b;
    code_len <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int                      sent;
    int                      r;
    int                      rl;
    bit                      drained;
    logic [SYM_W-1:0]        s;
    logic [LEN_FIELD_W-1:0]  l;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
    send(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    send(KIND_UNUSED, 8'hff, 32'hffff_ffff, 6'd63);
    send(KIND_LOAD, 8'h00, 32'hffff_ffff, 6'd0);
    send(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
    send(KIND_LOAD, 8'hff, 32'hffff_ffff, 6'd32);
    send(KIND_ENCODE, 8'hff, 32'h0, 6'd0);
    send(KIND_LOAD, 8'h01, 32'ha5a5_a5a5, 6'd63);
    send(KIND_LOAD, 8'h02, 32'hffff_ffff, 6'd3);
    send(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
    send(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    send(KIND_LOAD, 8'h03, 32'h0, 6'd8);
    send(KIND_ENCODE, 8'h03, 32'h0, 6'd0);
    send(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
    send(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
    send(KIND_ENCODE, 8'hff, 32'h0, 6'd0);
    send(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    send(KIND_LOAD, 8'h80, 32'h1234_5678, 6'd33);
    send(KIND_ENCODE, 8'h80, 32'h0, 6'd0);
    send(KIND_ENCODE, 8'h7f, 32'h0, 6'd0);
    send(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    send(KIND_FLUSH, 8'h00, 32'h0, 6'd0);

    sent = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
      if (sent == RANDOM_ITEMS / 2 && !drained) begin
        drained = 1'b1;
        drain();
      end
      r = $urandom_range(0, 99);
      s = ($urandom_range(0, 4) == 0) ? SYM_W'($urandom_range(0, 255))
                                      : SYM_W'($urandom_range(0, 15));
      if (r < 20) begin
        rl = $urandom_range(0, 19);
        if (rl < 2) l = '0;
        else if (rl < 4) l = LEN_FIELD_W'($urandom_range(33, 63));
        else if (rl < 7) l = 6'd32;
        else l = LEN_FIELD_W'($urandom_range(1, (rl < 13) ? 12 : 32));
        send(KIND_LOAD, s, $urandom, l);
        sent++;
      end else if (r < 85) begin
        send(KIND_ENCODE, s, $urandom, LEN_FIELD_W'($urandom));
        sent++;
      end else if (r < 95) begin
        send(KIND_FLUSH, s, $urandom, LEN_FIELD_W'($urandom));
        sent++;
      end else begin
        send(KIND_UNUSED, s, $urandom, LEN_FIELD_W'($urandom));
        sent++;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/pcbp_pkg.sv
src/pcbp_ram.sv
src/prefix_code_bit_packer.sv
test/pcbp_checker.sv
test/tb_prefix_code_bit_packer.sv
